// File: hw/rtl/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types, codes and defaults of the aging priority scheduler.
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int DEF_MAX_PROCESSES = 64;
  localparam int DEF_AGE_BITS      = 16;
  localparam int DEF_PRIORITY_BITS = 8;

  localparam int CMD_W  = 3;
  localparam int PID_W  = 7;
  localparam int NPRI_W = 8;
  localparam int ERR_W  = 2;

  localparam logic [CMD_W-1:0] CMD_SCHED = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FORK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_EXIT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KILL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NICE  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

  typedef enum logic [1:0] {
    ST_CREATED    = 2'd0,
    ST_READY      = 2'd1,
    ST_EXECUTING  = 2'd2,
    ST_TERMINATED = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    S_INIT     = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_FORK     = 7'b0000100,
    S_PASS     = 7'b0001000,
    S_FIN_CUR  = 7'b0010000,
    S_FIN_BEST = 7'b0100000,
    S_SPARE    = 7'b1000000
  } seq_state_t;

  typedef struct packed {
    logic st;
    logic pr;
    logic ag;
  } tbl_we_t;

endpackage

// File: hw/rtl/asp_table.sv
// ----------------------------------------------------------------------------
// asp_table
// Process table: status, priority and age memories with one shared
// registered read port and per-field write enables.
// ----------------------------------------------------------------------------
module asp_table import asp_pkg::*; #(
  parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
  parameter int AGE_BITS      = DEF_AGE_BITS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
  localparam int IDX_W        = $clog2(MAX_PROCESSES)
) (
  input  logic                     clk,
  input  logic [IDX_W-1:0]         rd_addr,
  input  tbl_we_t                  we,
  input  logic [IDX_W-1:0]         st_waddr,
  input  logic [IDX_W-1:0]         waddr,
  input  status_t                  st_wdata,
  input  logic [PRIORITY_BITS-1:0] pr_wdata,
  input  logic [AGE_BITS-1:0]      ag_wdata,
  output status_t                  st_rdata,
  output logic [PRIORITY_BITS-1:0] pr_rdata,
  output logic [AGE_BITS-1:0]      ag_rdata
);

  status_t                  st_mem [MAX_PROCESSES];
  logic [PRIORITY_BITS-1:0] pr_mem [MAX_PROCESSES];
  logic [AGE_BITS-1:0]      ag_mem [MAX_PROCESSES];

  always_ff @(posedge clk) begin
    if (we.st) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (we.pr) begin
      pr_mem[waddr] <= pr_wdata;
    end
    if (we.ag) begin
      ag_mem[waddr] <= ag_wdata;
    end
    st_rdata <= st_mem[rd_addr];
    pr_rdata <= pr_mem[rd_addr];
    ag_rdata <= ag_mem[rd_addr];
  end

endmodule

// File: hw/rtl/asp_age_unit.sv
// ----------------------------------------------------------------------------
// asp_age_unit
// Shared age unit: saturating age plus priority, and the age compare used
// by the candidate search.
// ----------------------------------------------------------------------------
module asp_age_unit import asp_pkg::*; #(
  parameter int AGE_BITS      = DEF_AGE_BITS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic [AGE_BITS-1:0]      age_in,
  input  logic [PRIORITY_BITS-1:0] prio_in,
  input  logic [AGE_BITS-1:0]      best_age,
  output logic [AGE_BITS-1:0]      age_sum,
  output logic                     age_ge
);

  localparam int SUM_W = ((AGE_BITS > PRIORITY_BITS) ? AGE_BITS : PRIORITY_BITS) + 1;
  localparam logic [SUM_W-1:0] AGE_MAX = SUM_W'({AGE_BITS{1'b1}});

  logic [SUM_W-1:0] sum;

  assign sum     = SUM_W'(age_in) + SUM_W'(prio_in);
  assign age_sum = (sum > AGE_MAX) ? {AGE_BITS{1'b1}} : AGE_BITS'(sum);
  assign age_ge  = (age_in >= best_age);

endmodule

// File: hw/rtl/aging_priority_scheduler.sv
// ----------------------------------------------------------------------------
// aging_priority_scheduler
// Process table scheduler with priority aging, run by a small sequencer
// over one table read port and one shared age unit.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Handshake
//  request   cmd, target_pid, prio_value               start and not busy
//  result    switched, last_pid, chosen_pid,           done, one cycle
//            child_pid, error_code
//
// Kill, nice and unknown commands finish from the idle state; fork passes
// through the fork state, unless the table is full.
// Schedule and exit make one pass over the allocated entries through the single
// table read port, then finish the current and the chosen entry.
// After reset the block is busy while it writes entry 0.
// Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module aging_priority_scheduler import asp_pkg::*; #(
  parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
  parameter int AGE_BITS      = DEF_AGE_BITS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [PID_W-1:0]  target_pid,
  input  logic [NPRI_W-1:0] prio_value,
  output logic              done,
  output logic              switched,
  output logic [PID_W-1:0]  last_pid,
  output logic [PID_W-1:0]  chosen_pid,
  output logic [PID_W-1:0]  child_pid,
  output logic [ERR_W-1:0]  error_code
);

  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int LC_W  = $clog2(MAX_PROCESSES + 1);
  localparam logic [PID_W+1:0] MAX_PID = (PID_W + 2)'(MAX_PROCESSES);
  localparam logic [LC_W-1:0]  MAX_LC  = LC_W'(MAX_PROCESSES);

  seq_state_t state;

  logic [IDX_W-1:0]    running_index;
  logic [LC_W-1:0]     live_count;
  logic [LC_W-1:0]     ri;
  logic                v_d;
  logic [IDX_W-1:0]    idx_d;
  logic                have;
  logic [IDX_W-1:0]    best;
  logic [AGE_BITS-1:0] best_age;
  logic                is_exit;
  status_t             cur_st;

  logic                     accept;
  logic                     pid_ok;
  logic [IDX_W-1:0]         pid_idx;
  logic [PRIORITY_BITS-1:0] prio_in;
  logic                     at_cur;
  logic                     live_d;
  logic [AGE_BITS-1:0]      age_eff;
  logic [AGE_BITS-1:0]      age_sum;
  logic                     age_ge;

  logic [IDX_W-1:0]         rd_addr;
  tbl_we_t                  we;
  logic [IDX_W-1:0]         st_waddr;
  logic [IDX_W-1:0]         waddr;
  status_t                  st_wdata;
  logic [PRIORITY_BITS-1:0] pr_wdata;
  logic [AGE_BITS-1:0]      ag_wdata;
  status_t                  st_rdata;
  logic [PRIORITY_BITS-1:0] pr_rdata;
  logic [AGE_BITS-1:0]      ag_rdata;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign pid_ok  = (target_pid != '0) && ({2'b00, target_pid} <= MAX_PID);
  assign pid_idx = IDX_W'(target_pid - PID_W'(1));
  assign prio_in = PRIORITY_BITS'(prio_value);
  assign at_cur  = (idx_d == running_index);
  assign age_eff = at_cur ? '0 : ag_rdata;
  assign live_d  = (st_rdata != ST_TERMINATED) && !(is_exit && at_cur);

  asp_table #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .AGE_BITS      (AGE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_table (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .we       (we),
    .st_waddr (st_waddr),
    .waddr    (waddr),
    .st_wdata (st_wdata),
    .pr_wdata (pr_wdata),
    .ag_wdata (ag_wdata),
    .st_rdata (st_rdata),
    .pr_rdata (pr_rdata),
    .ag_rdata (ag_rdata)
  );

  asp_age_unit #(
    .AGE_BITS      (AGE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_age_unit (
    .age_in   (age_eff),
    .prio_in  (pr_rdata),
    .best_age (best_age),
    .age_sum  (age_sum),
    .age_ge   (age_ge)
  );

  always_comb begin
    we       = '0;
    rd_addr  = running_index;
    st_waddr = running_index;
    waddr    = idx_d;
    st_wdata = ST_READY;
    pr_wdata = pr_rdata;
    ag_wdata = age_sum;
    unique case (state)
      S_INIT: begin
        we       = '{st: 1'b1, pr: 1'b1, ag: 1'b1};
        st_waddr = '0;
        waddr    = '0;
        st_wdata = ST_CREATED;
        pr_wdata = PRIORITY_BITS'(1);
        ag_wdata = '0;
      end
      S_IDLE: begin
        if (accept && pid_ok && (cmd == CMD_KILL)) begin
          we.st    = 1'b1;
          st_waddr = pid_idx;
          st_wdata = ST_TERMINATED;
        end
        if (accept && pid_ok && (cmd == CMD_NICE)) begin
          we.pr    = 1'b1;
          waddr    = pid_idx;
          pr_wdata = prio_in;
        end
      end
      S_FORK: begin
        we       = '{st: 1'b1, pr: 1'b1, ag: 1'b1};
        st_waddr = live_count[IDX_W-1:0];
        waddr    = live_count[IDX_W-1:0];
        st_wdata = ST_CREATED;
        pr_wdata = pr_rdata;
        ag_wdata = ag_rdata;
      end
      S_PASS: begin
        rd_addr = ri[IDX_W-1:0];
        we.ag   = v_d;
      end
      S_FIN_CUR: begin
        we.st    = 1'b1;
        we.ag    = 1'b1;
        st_wdata = (is_exit || (cur_st == ST_TERMINATED)) ? ST_TERMINATED : ST_READY;
        waddr    = best;
        ag_wdata = best_age;
      end
      S_FIN_BEST: begin
        we.st    = 1'b1;
        st_waddr = best;
        st_wdata = ST_EXECUTING;
      end
      default: begin
        we = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      live_count    <= LC_W'(1);
      running_index <= '0;
      done          <= 1'b0;
      v_d           <= 1'b0;
      have          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            switched   <= 1'b0;
            last_pid   <= '0;
            chosen_pid <= '0;
            child_pid  <= '0;
            error_code <= ERR_OK;
            if ((cmd == CMD_SCHED) || (cmd == CMD_EXIT)) begin
              is_exit <= (cmd == CMD_EXIT);
              ri      <= '0;
              v_d     <= 1'b0;
              have    <= 1'b0;
              state   <= S_PASS;
            end else if (cmd == CMD_FORK) begin
              if (live_count >= MAX_LC) begin
                error_code <= ERR_FULL;
                done       <= 1'b1;
              end else begin
                state <= S_FORK;
              end
            end else if ((cmd == CMD_KILL) || (cmd == CMD_NICE)) begin
              if (!pid_ok) begin
                error_code <= ERR_RANGE;
              end
              done <= 1'b1;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_FORK: begin
          live_count <= live_count + LC_W'(1);
          child_pid  <= PID_W'(live_count) + PID_W'(1);
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_PASS: begin
          if (ri < live_count) begin
            ri    <= ri + LC_W'(1);
            v_d   <= 1'b1;
            idx_d <= ri[IDX_W-1:0];
          end else begin
            v_d <= 1'b0;
          end
          if (v_d) begin
            if (live_d && (!have || age_ge)) begin
              best     <= idx_d;
              best_age <= age_eff;
              have     <= 1'b1;
            end else if (idx_d == '0) begin
              best     <= '0;
              best_age <= age_eff;
            end
            if (at_cur) begin
              cur_st <= st_rdata;
            end
            if (ri == live_count) begin
              state <= S_FIN_CUR;
            end
          end
        end
        S_FIN_CUR: begin
          state <= S_FIN_BEST;
        end
        S_FIN_BEST: begin
          running_index <= best;
          switched      <= 1'b1;
          last_pid      <= PID_W'(running_index) + PID_W'(1);
          chosen_pid    <= PID_W'(best) + PID_W'(1);
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/tb_aging_priority_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aging_priority_scheduler
// Self-checking testbench for the aging priority scheduler. A driver feeds
// requests from a queue with random gaps, and a predictor of the process
// table computes the expected result of each accepted request. A monitor
// compares every strobed result, field by field, with the oldest expected
// result. A short directed sequence comes first, then random traffic that
// fills the table and mixes schedules, exits, kills and priority changes.
// ----------------------------------------------------------------------------
module tb_aging_priority_scheduler;
  import asp_pkg::*;

  localparam int NPROC      = DEF_MAX_PROCESSES;
  localparam int AGE_W      = DEF_AGE_BITS;
  localparam int PRIO_W     = DEF_PRIORITY_BITS;
  localparam int N_RANDOM   = 380;
  localparam int MAX_GAP    = 9;
  localparam int DRAIN_CYC  = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_NICE + 3'd1;
  localparam logic [CMD_W-1:0] CMD_LAST_CODE    = '1;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [PID_W-1:0]  pid;
    logic [NPRI_W-1:0] prio;
  } req_t;

  typedef struct {
    logic             switched;
    logic [PID_W-1:0] last_pid;
    logic [PID_W-1:0] chosen_pid;
    logic [PID_W-1:0] child_pid;
    logic [ERR_W-1:0] error_code;
    int               tag;
  } sched_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [CMD_W-1:0]  cmd = CMD_SCHED;
  logic [PID_W-1:0]  target_pid = '0;
  logic [NPRI_W-1:0] prio_value = '0;
  logic              busy;
  logic              done;
  logic              switched;
  logic [PID_W-1:0]  last_pid;
  logic [PID_W-1:0]  chosen_pid;
  logic [PID_W-1:0]  child_pid;
  logic [ERR_W-1:0]  error_code;

  req_t       request_q[$];
  sched_res_t expected_q[$];
  int         cyc = 0;
  int         n_total = 0;
  int         n_sent = 0;
  int         n_errors = 0;
  int         gap_left = 0;

  status_t            tbl_status[NPROC];
  logic [PRIO_W-1:0]  tbl_prio[NPROC];
  logic [AGE_W-1:0]   tbl_age[NPROC];
  int                 tbl_live;
  int                 tbl_running;

  aging_priority_scheduler uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .target_pid(target_pid),
    .prio_value(prio_value),
    .done(done),
    .switched(switched),
    .last_pid(last_pid),
    .chosen_pid(chosen_pid),
    .child_pid(child_pid),
    .error_code(error_code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void table_reset();
    for (int i = 0; i < NPROC; i++) begin
      tbl_status[i] = ST_TERMINATED;
      tbl_prio[i]   = '0;
      tbl_age[i]    = '0;
    end
    tbl_status[0] = ST_CREATED;
    tbl_prio[0]   = PRIO_W'(1);
    tbl_live      = 1;
    tbl_running   = 0;
  endfunction

  // Clears the running entry's age, picks the oldest live entry and ages
  // every other allocated entry by its own priority, saturating.
  function automatic int pick_next_process();
    int best;
    bit have;
    logic [AGE_W:0] sum;
    best = 0;
    have = 1'b0;
    tbl_age[tbl_running] = '0;
    for (int i = 0; i < tbl_live; i++) begin
      if (tbl_status[i] != ST_TERMINATED && (!have || tbl_age[i] >= tbl_age[best])) begin
        best = i;
        have = 1'b1;
      end
    end
    if (tbl_status[tbl_running] != ST_TERMINATED)
      tbl_status[tbl_running] = ST_READY;
    tbl_status[best] = ST_EXECUTING;
    for (int i = 0; i < tbl_live; i++) begin
      if (i != best) begin
        sum = {1'b0, tbl_age[i]} + (AGE_W + 1)'(tbl_prio[i]);
        tbl_age[i] = sum[AGE_W] ? '1 : sum[AGE_W-1:0];
      end
    end
    tbl_running = best;
    return best;
  endfunction

  function automatic sched_res_t predict_result(req_t r);
    sched_res_t e;
    int cur;
    int n;
    e = '{switched: 1'b0, last_pid: '0, chosen_pid: '0, child_pid: '0,
          error_code: ERR_OK, tag: 0};
    cur = tbl_running;
    case (r.cmd)
      CMD_SCHED, CMD_EXIT: begin
        if (r.cmd == CMD_EXIT)
          tbl_status[cur] = ST_TERMINATED;
        e.switched   = 1'b1;
        e.last_pid   = PID_W'(cur + 1);
        e.chosen_pid = PID_W'(pick_next_process() + 1);
      end
      CMD_FORK: begin
        if (tbl_live >= NPROC) begin
          e.error_code = ERR_FULL;
        end else begin
          n = tbl_live;
          tbl_status[n] = ST_CREATED;
          tbl_prio[n]   = tbl_prio[cur];
          tbl_age[n]    = tbl_age[cur];
          tbl_live      = n + 1;
          e.child_pid   = PID_W'(n + 1);
        end
      end
      CMD_KILL, CMD_NICE: begin
        if (r.pid == 0 || r.pid > NPROC)
          e.error_code = ERR_RANGE;
        else if (r.cmd == CMD_KILL)
          tbl_status[r.pid - 1] = ST_TERMINATED;
        else
          tbl_prio[r.pid - 1] = r.prio[PRIO_W-1:0];
      end
      default: ;
    endcase
    return e;
  endfunction

  function automatic void add_request(logic [CMD_W-1:0] c, logic [PID_W-1:0] p,
                                      logic [NPRI_W-1:0] pr);
    req_t r;
    r.cmd  = c;
    r.pid  = p;
    r.prio = pr;
    request_q.push_back(r);
  endfunction

  function automatic logic [PID_W-1:0] pick_pid(int live_guess);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0)
      return '0;
    if (sel == 1)
      return PID_W'($urandom_range(NPROC + 1, (1 << PID_W) - 1));
    return PID_W'($urandom_range(1, (live_guess + 1 > NPROC) ? NPROC : live_guess + 1));
  endfunction

  // Driver: a request stays on the ports until the block takes it.
  always @(posedge clk) begin
    sched_res_t e;
    int no_idle;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        e = predict_result('{cmd: cmd, pid: target_pid, prio: prio_value});
        e.tag = cyc;
        expected_q.push_back(e);
        n_sent++;
      end
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (request_q.size() != 0) begin
          req_t r;
          r = request_q.pop_front();
          cmd <= r.cmd;
          target_pid <= r.pid;
          prio_value <= r.prio;
          start <= 1'b1;
          no_idle = ($urandom_range(0, 3) == 0);
          gap_left <= no_idle ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: a result taken at the same edge as a request cannot belong to it.
  always @(posedge clk) begin
    sched_res_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0 || expected_q[0].tag == cyc) begin
        $error("result with no request outstanding");
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (switched !== e.switched) begin
          $error("switched: expected %0d, actual %0d", e.switched, switched);
          n_errors++;
        end
        if (last_pid !== e.last_pid) begin
          $error("last_pid: expected %0d, actual %0d", e.last_pid, last_pid);
          n_errors++;
        end
        if (chosen_pid !== e.chosen_pid) begin
          $error("chosen_pid: expected %0d, actual %0d", e.chosen_pid, chosen_pid);
          n_errors++;
        end
        if (child_pid !== e.child_pid) begin
          $error("child_pid: expected %0d, actual %0d", e.child_pid, child_pid);
          n_errors++;
        end
        if (error_code !== e.error_code) begin
          $error("error_code: expected %0d, actual %0d", e.error_code, error_code);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int live_guess;
    int sel;
    logic [CMD_W-1:0] c;
    table_reset();

    // Directed requests: lone entry, range errors, unallocated writes,
    // unknown commands and a schedule with every entry terminated.
    add_request(CMD_SCHED, '0, '0);
    add_request(CMD_FORK, '0, '0);
    add_request(CMD_FORK, '0, '0);
    add_request(CMD_NICE, 7'd1, 8'd0);
    add_request(CMD_NICE, 7'd2, 8'd255);
    add_request(CMD_NICE, 7'd64, 8'd170);
    add_request(CMD_KILL, 7'd0, 8'd0);
    add_request(CMD_KILL, 7'd65, 8'd0);
    add_request(CMD_NICE, 7'd127, 8'd85);
    add_request(CMD_NICE, 7'd0, 8'd255);
    add_request(CMD_SCHED, '0, '0);
    add_request(CMD_EXIT, '0, '0);
    for (c = CMD_FIRST_UNUSED; c <= CMD_LAST_CODE && c >= CMD_FIRST_UNUSED; c++)
      add_request(c, '1, '1);
    add_request(CMD_KILL, 7'd64, 8'd0);
    add_request(CMD_KILL, 7'd1, 8'd0);
    add_request(CMD_KILL, 7'd2, 8'd0);
    add_request(CMD_KILL, 7'd3, 8'd0);
    add_request(CMD_SCHED, '0, '0);
    add_request(CMD_FORK, '0, '0);
    add_request(CMD_SCHED, '0, '0);
    live_guess = 4;

    for (int k = 0; k < N_RANDOM; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        add_request(CMD_SCHED, PID_W'($urandom), NPRI_W'($urandom));
      end else if (sel < 57) begin
        add_request(CMD_FORK, PID_W'($urandom), NPRI_W'($urandom));
        if (live_guess < NPROC)
          live_guess++;
      end else if (sel < 62) begin
        add_request(CMD_EXIT, PID_W'($urandom), NPRI_W'($urandom));
      end else if (sel < 68) begin
        add_request(CMD_KILL, pick_pid(live_guess), NPRI_W'($urandom));
      end else if (sel < 95) begin
        add_request(CMD_NICE, pick_pid(live_guess), NPRI_W'($urandom));
      end else begin
        add_request(CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE)),
                    PID_W'($urandom), NPRI_W'($urandom));
      end
    end
    n_total = request_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (!(n_sent == n_total && expected_q.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
